// ----- design/tsp_pkg.sv -----
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants for the tagged slot pool
// Function codes, scan length reset and clone limit constants, slot entry
// layout, result bundle and the controller state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

  // Request function codes
  localparam logic [2:0] FN_FIND    = 3'd0;
  localparam logic [2:0] FN_CLAIM   = 3'd1;
  localparam logic [2:0] FN_LOAD    = 3'd2;
  localparam logic [2:0] FN_FLUSH   = 3'd3;
  localparam logic [2:0] FN_RELEASE = 3'd4;

  // Reset value of the scan length register
  localparam logic [4:0] CFG_SLOTS_RESET = 5'd16;

  // Saturation limit of the clone count
  localparam logic [4:0] CLONE_MAX = 5'd31;

  // One slot as held in the memory
  typedef struct packed {
    logic [15:0] ctx;
    logic [15:0] tag;
    logic [31:0] last_use;
  } entry_t;

  // One result transaction
  typedef struct packed {
    logic        hit;
    logic [3:0]  found_index;
    logic [4:0]  clone_count;
    logic        evicted;
    logic [15:0] evicted_context;
  } result_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_LOAD,
    ST_FLUSH,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- design/tsp_if.sv -----
// ----------------------------------------------------------------------------
// tsp_if: channel interfaces of the tagged slot pool
// Request, response and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tsp_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [15:0] tag;
  logic [3:0]  slot_index;
  logic [15:0] context_id;
  logic [31:0] now;

  modport source (output valid, func, tag, slot_index, context_id, now, input ready);
  modport sink   (input valid, func, tag, slot_index, context_id, now, output ready);
endinterface

interface tsp_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [3:0]  found_index;
  logic [4:0]  clone_count;
  logic        evicted;
  logic [15:0] evicted_context;

  modport source (output valid, hit, found_index, clone_count, evicted, evicted_context,
                  input ready);
  modport sink   (input valid, hit, found_index, clone_count, evicted, evicted_context,
                  output ready);
endinterface

interface tsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- design/tsp_slot_mem.sv -----
// ----------------------------------------------------------------------------
// tsp_slot_mem: slot table storage
// Single write / single read synchronous memory with a registered read.
// Per-entry valid flags make unwritten or flushed slots read as all zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsp_slot_mem #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [IW-1:0]     rd_addr,
  input  wire logic              we,
  input  wire logic              clr,
  input  wire logic [IW-1:0]     wr_addr,
  input  wire tsp_pkg::entry_t   wr_data,
  output tsp_pkg::entry_t        rd_entry,
  output logic [IW-1:0]          rd_idx
);

  tsp_pkg::entry_t mem [SLOTS];
  tsp_pkg::entry_t rd_q;
  logic [SLOTS-1:0] valid;
  logic             rd_vld;

  // Data array: write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q   <= mem[rd_addr];
    rd_idx <= rd_addr;
  end

  // Entry valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        valid[wr_addr] <= 1'b1;
      end else if (clr) begin
        valid[wr_addr] <= 1'b0;
      end
      rd_vld <= (32'(rd_addr) < 32'(SLOTS)) && valid[rd_addr];
    end
  end

  // Empty slots read as zero
  assign rd_entry = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

// ----- design/tsp_seq.sv -----
// ----------------------------------------------------------------------------
// tsp_seq: request sequencer of the tagged slot pool
// Accepts requests, scans the slot memory one slot per cycle, tracks the
// busy marks, and writes back finds, claim evictions, loads and flushes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsp_seq #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  tsp_req_if.sink              req,
  input  wire logic [4:0]      slots_in_use,
  input  wire tsp_pkg::entry_t rd_entry,
  input  wire logic [IW-1:0]   rd_idx,
  output logic [IW-1:0]        rd_addr,
  output logic                 we,
  output logic                 clr,
  output logic [IW-1:0]        wr_addr,
  output tsp_pkg::entry_t      wr_data,
  output logic                 res_valid,
  output tsp_pkg::result_t     res,
  input  wire logic            res_take
);

  localparam int CW = $clog2(SLOTS + 1);

  tsp_pkg::state_t state, state_next;

  logic [2:0]       op;
  logic [15:0]      rq_tag;
  logic [IW-1:0]    rq_idx;
  logic [15:0]      rq_ctx;
  logic [31:0]      rq_now;
  logic             rq_inr;
  logic [IW-1:0]    last_idx;
  logic [IW-1:0]    iss;
  logic [4:0]       clones;
  logic             have;
  logic             empty;
  logic [IW-1:0]    pick;
  logic [15:0]      pick_ctx;
  logic [31:0]      best;
  logic [SLOTS-1:0] busy;

  logic          accept;
  logic          is_scan;
  logic          in_range;
  logic [CW-1:0] scan_n;
  logic          cur_busy;
  logic          find_match;
  logic          find_take;
  logic          claim_empty;
  logic          claim_better;
  logic          scan_end;
  logic          evict;

  // Request decode
  assign accept   = req.valid && req.ready;
  assign is_scan  = (req.func == tsp_pkg::FN_FIND) || (req.func == tsp_pkg::FN_CLAIM);
  assign in_range = 32'(req.slot_index) < 32'(SLOTS);
  assign scan_n   = (32'(slots_in_use) > 32'(SLOTS)) ? CW'(SLOTS) : CW'(slots_in_use);

  // Per-slot scan evaluation
  assign cur_busy     = busy[rd_idx];
  assign find_match   = (rd_entry.ctx != 16'd0) && (rd_entry.tag == rq_tag);
  assign find_take    = find_match && !cur_busy;
  assign claim_empty  = !cur_busy && (rd_entry.ctx == 16'd0);
  assign claim_better = !cur_busy && (rd_entry.ctx != 16'd0) &&
                        (!have || (rd_entry.last_use < best));
  assign scan_end     = ((op == tsp_pkg::FN_FIND) ? find_take : claim_empty) ||
                        (rd_idx == last_idx);
  assign evict        = (op == tsp_pkg::FN_CLAIM) && have && !empty;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tsp_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_scan) begin
            state_next = (scan_n == '0) ? tsp_pkg::ST_DONE : tsp_pkg::ST_SCAN;
          end else if (req.func == tsp_pkg::FN_LOAD) begin
            state_next = tsp_pkg::ST_LOAD;
          end else if (req.func == tsp_pkg::FN_FLUSH) begin
            state_next = tsp_pkg::ST_FLUSH;
          end else begin
            state_next = tsp_pkg::ST_DONE;
          end
        end
      end
      tsp_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = tsp_pkg::ST_PICK;
        end
      end
      tsp_pkg::ST_PICK:  state_next = tsp_pkg::ST_DONE;
      tsp_pkg::ST_LOAD:  state_next = tsp_pkg::ST_DONE;
      tsp_pkg::ST_FLUSH: state_next = tsp_pkg::ST_DONE;
      tsp_pkg::ST_DONE: begin
        if (res_take) begin
          state_next = tsp_pkg::ST_IDLE;
        end
      end
      default: state_next = tsp_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and memory access
  always_comb begin
    req.ready = 1'b0;
    res_valid = 1'b0;
    rd_addr   = iss;
    we        = 1'b0;
    clr       = 1'b0;
    wr_addr   = rq_idx;
    wr_data   = '{ctx: rq_ctx, tag: rq_tag, last_use: rq_now};
    unique case (state)
      tsp_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        rd_addr   = is_scan ? '0 : IW'(req.slot_index);
      end
      tsp_pkg::ST_PICK: begin
        wr_addr = pick;
        wr_data = '{ctx: pick_ctx, tag: rq_tag, last_use: rq_now};
        we      = (op == tsp_pkg::FN_FIND) && have;
        clr     = evict;
      end
      tsp_pkg::ST_LOAD: begin
        we = rq_inr;
        if (rq_tag == 16'd0) begin
          wr_data.tag = rd_entry.tag;
        end
      end
      tsp_pkg::ST_FLUSH: begin
        clr = rq_inr;
      end
      tsp_pkg::ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Busy marks
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (accept && (req.func == tsp_pkg::FN_RELEASE) && in_range) begin
      busy[IW'(req.slot_index)] <= 1'b0;
    end else if ((state == tsp_pkg::ST_PICK) && have) begin
      busy[pick] <= 1'b1;
    end
  end

  // Request capture, scan tracking and result
  always_ff @(posedge clk) begin
    unique case (state)
      tsp_pkg::ST_IDLE: begin
        if (accept) begin
          op       <= req.func;
          rq_tag   <= req.tag;
          rq_idx   <= IW'(req.slot_index);
          rq_ctx   <= req.context_id;
          rq_now   <= req.now;
          rq_inr   <= in_range;
          last_idx <= IW'(scan_n - CW'(1));
          iss      <= IW'(1);
          clones   <= '0;
          have     <= 1'b0;
          empty    <= 1'b0;
          pick     <= '0;
          pick_ctx <= '0;
          best     <= '0;
          res      <= '0;
        end
      end
      tsp_pkg::ST_SCAN: begin
        iss <= iss + IW'(1);
        if (op == tsp_pkg::FN_FIND) begin
          if (find_match && (clones != tsp_pkg::CLONE_MAX)) begin
            clones <= clones + 5'd1;
          end
          if (find_take) begin
            have     <= 1'b1;
            pick     <= rd_idx;
            pick_ctx <= rd_entry.ctx;
          end
        end else if (claim_empty) begin
          have  <= 1'b1;
          empty <= 1'b1;
          pick  <= rd_idx;
        end else if (claim_better) begin
          have     <= 1'b1;
          best     <= rd_entry.last_use;
          pick     <= rd_idx;
          pick_ctx <= rd_entry.ctx;
        end
      end
      tsp_pkg::ST_PICK: begin
        res.hit             <= have;
        res.found_index     <= have ? 4'(pick) : 4'd0;
        res.clone_count     <= (op == tsp_pkg::FN_FIND) ? clones : 5'd0;
        res.evicted         <= evict;
        res.evicted_context <= evict ? pick_ctx : 16'd0;
      end
      tsp_pkg::ST_FLUSH: begin
        if (rq_inr && (rd_entry.ctx != 16'd0)) begin
          res.evicted         <= 1'b1;
          res.evicted_context <= rd_entry.ctx;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/tagged_slot_pool_lru.sv -----
// ----------------------------------------------------------------------------
// tagged_slot_pool_lru: execution context slot pool with LRU replacement
// Top level: scan length register, result output register, sequencer and
// slot memory.
//
//   channel  dir  transaction carries
//   -------  ---  -------------------------------------------------------
//   req      in   func, tag, slot_index, context_id, now
//   rsp      out  hit, found_index, clone_count, evicted, evicted_context
//   cfg      in   data: slots_in_use (5 bits)
//
// find / claim: the scan covers n slots, n being the scan length capped at
// SLOTS (fewer on an early hit); the memory read port delivers one slot per
// cycle. load and flush pass through a write state, others go straight to the result.
// Reset is synchronous; slot entries are emptied at once by valid flags.
// The result waits in the output register while the next request is taken;
// a new result stalls only while that register is full and rsp.ready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tagged_slot_pool_lru #(
  parameter int SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  tsp_req_if.sink   req,
  tsp_rsp_if.source rsp,
  tsp_cfg_if.sink   cfg
);

  localparam int IW = $clog2(SLOTS);

  logic [4:0]       slots_in_use;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    rd_idx;
  logic [IW-1:0]    wr_addr;
  logic             we;
  logic             clr;
  tsp_pkg::entry_t  wr_data;
  tsp_pkg::entry_t  rd_entry;
  logic             res_valid;
  logic             res_take;
  tsp_pkg::result_t res;
  tsp_pkg::result_t out_q;
  logic             out_valid;

  // Scan length register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= tsp_pkg::CFG_SLOTS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      slots_in_use <= cfg.data;
    end
  end

  // Output register
  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.hit             = out_q.hit;
  assign rsp.found_index     = out_q.found_index;
  assign rsp.clone_count     = out_q.clone_count;
  assign rsp.evicted         = out_q.evicted;
  assign rsp.evicted_context = out_q.evicted_context;

  // Sequencer
  tsp_seq #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .slots_in_use (slots_in_use),
    .rd_entry     (rd_entry),
    .rd_idx       (rd_idx),
    .rd_addr      (rd_addr),
    .we           (we),
    .clr          (clr),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  // Slot memory
  tsp_slot_mem #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .we       (we),
    .clr      (clr),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_entry (rd_entry),
    .rd_idx   (rd_idx)
  );

endmodule

`default_nettype wire

// ----- test/tagged_slot_pool_lru_tb.sv -----
// ----------------------------------------------------------------------------
// tagged_slot_pool_lru_tb: self-checking bench for the tagged slot pool
// Drives find/claim/load/flush/release requests with random gaps and
// response stalls. A slot table tracker predicts each response and
// checks every field in order. Scan length is changed between phases
// while the pool is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tagged_slot_pool_lru_tb;

  localparam int POOL_SLOTS = 16;

  // Tracks slot table contents and the queue of predicted responses
  class slot_pool_tracker;
    logic [4:0]        scan_limit;
    logic [15:0]       ctx_mem[POOL_SLOTS];
    logic [15:0]       tag_mem[POOL_SLOTS];
    bit                busy_mem[POOL_SLOTS];
    logic [31:0]       last_use_mem[POOL_SLOTS];
    tsp_pkg::result_t  outcome_q[$];
    tsp_pkg::result_t  newest;
    int                mismatches;

    function new();
      scan_limit = tsp_pkg::CFG_SLOTS_RESET;
      mismatches = 0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
        ctx_mem[i]      = '0;
        tag_mem[i]      = '0;
        busy_mem[i]     = 1'b0;
        last_use_mem[i] = '0;
      end
    endfunction

    function void set_scan_limit(logic [4:0] v);
      scan_limit = v;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    // Apply one accepted request to the table, queue its response
    function void note_request(logic [2:0] fn, logic [15:0] tg, logic [3:0] idx,
                               logic [15:0] cid, logic [31:0] stamp);
      int               span;
      int               pick;
      bit               have;
      bit               empty;
      logic [31:0]      best;
      tsp_pkg::result_t r;
      r     = '0;
      pick  = 0;
      have  = 1'b0;
      empty = 1'b0;
      best  = '0;
      span  = (scan_limit > 5'(POOL_SLOTS)) ? POOL_SLOTS : int'(scan_limit);
      case (fn)
        tsp_pkg::FN_FIND: begin
          for (int i = 0; i < span; i++) begin
            if (ctx_mem[i] != 0 && tag_mem[i] == tg) begin
              if (r.clone_count < tsp_pkg::CLONE_MAX) begin
                r.clone_count = r.clone_count + 5'd1;
              end
              if (!busy_mem[i]) begin
                busy_mem[i]     = 1'b1;
                last_use_mem[i] = stamp;
                r.hit           = 1'b1;
                r.found_index   = 4'(i);
                break;
              end
            end
          end
        end
        tsp_pkg::FN_CLAIM: begin
          // empty idle slot wins, else oldest idle slot, lowest index on ties
          for (int i = 0; i < span; i++) begin
            if (busy_mem[i]) continue;
            if (ctx_mem[i] == 0) begin
              pick  = i;
              have  = 1'b1;
              empty = 1'b1;
              break;
            end
            if (!have || last_use_mem[i] < best) begin
              best = last_use_mem[i];
              pick = i;
              have = 1'b1;
            end
          end
          if (have) begin
            if (!empty) begin
              r.evicted          = 1'b1;
              r.evicted_context  = ctx_mem[pick];
              ctx_mem[pick]      = '0;
              tag_mem[pick]      = '0;
              last_use_mem[pick] = '0;
            end
            busy_mem[pick] = 1'b1;
            r.hit          = 1'b1;
            r.found_index  = 4'(pick);
          end
        end
        tsp_pkg::FN_LOAD: begin
          ctx_mem[idx] = cid;
          if (tg != 0) tag_mem[idx] = tg;
          last_use_mem[idx] = stamp;
        end
        tsp_pkg::FN_FLUSH: begin
          if (ctx_mem[idx] != 0) begin
            r.evicted         = 1'b1;
            r.evicted_context = ctx_mem[idx];
          end
          ctx_mem[idx]      = '0;
          tag_mem[idx]      = '0;
          last_use_mem[idx] = '0;
        end
        tsp_pkg::FN_RELEASE: busy_mem[idx] = 1'b0;
        default: ;
      endcase
      newest = r;
      outcome_q.push_back(r);
    endfunction

    function void compare_field(string fld, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
      end
    endfunction

    // Compare one accepted response with the oldest prediction
    function void check_outcome(tsp_pkg::result_t got);
      tsp_pkg::result_t want;
      if (outcome_q.size() == 0) begin
        mismatches++;
        $display("%0t: response with none pending, expected nothing, actual %h",
                 $time, got);
        return;
      end
      want = outcome_q.pop_front();
      compare_field("hit", want.hit, got.hit);
      compare_field("found_index", want.found_index, got.found_index);
      compare_field("clone_count", want.clone_count, got.clone_count);
      compare_field("evicted", want.evicted, got.evicted);
      compare_field("evicted_context", want.evicted_context, got.evicted_context);
    endfunction
  endclass

  logic clk;
  logic rst;

  tsp_req_if req_ch();
  tsp_rsp_if rsp_ch();
  tsp_cfg_if cfg_ch();

  tagged_slot_pool_lru #(.SLOTS(POOL_SLOTS)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  slot_pool_tracker sb;
  bit               src_steady;
  bit               snk_steady;
  logic [31:0]      clock_now;
  int               held_q[$];
  int               load_slot;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #6_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Send one request; the prediction is made at acceptance
  task automatic send_request(input logic [2:0] fn, input logic [15:0] tg,
                              input logic [3:0] idx, input logic [15:0] cid,
                              input logic [31:0] stamp);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= fn;
    req_ch.tag        <= tg;
    req_ch.slot_index <= idx;
    req_ch.context_id <= cid;
    req_ch.now        <= stamp;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(fn, tg, idx, cid, stamp);
  endtask

  // Hold requests until every predicted response has come back
  task automatic drain_pool();
    if (sb.pending() != 0) begin
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
    end
  endtask

  task automatic write_scan_limit(input logic [4:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_scan_limit(v);
    cfg_ch.valid <= 1'b0;
  endtask

  // Small tag pool so that matches and clones are common
  function automatic logic [15:0] pick_tag();
    if ($urandom_range(0, 9) < 8) return 16'($urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_ctx();
    if ($urandom_range(0, 9) == 0) return 16'h0000;
    return 16'($urandom_range(1, 65535));
  endfunction

  // Mostly rising time stamps, with repeats for ties and random jumps
  function automatic logic [31:0] pick_now();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom;
    if (r > 2) clock_now = clock_now + 32'($urandom_range(1, 50));
    return clock_now;
  endfunction

  // Dispatch-like traffic: find, else claim then load; release what was taken
  task automatic run_traffic(input int count);
    int          r;
    int          pos;
    logic [3:0]  s;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 49) == 0) drain_pool();
      if (load_slot >= 0 && $urandom_range(0, 9) < 8) begin
        send_request(tsp_pkg::FN_LOAD, pick_tag(), 4'(load_slot), pick_ctx(), pick_now());
        load_slot = -1;
        continue;
      end
      load_slot = -1;
      r = $urandom_range(0, 99);
      if (r < 28) begin
        send_request(tsp_pkg::FN_FIND, pick_tag(), 4'($urandom), 16'($urandom),
                     pick_now());
        if (sb.newest.hit) held_q.push_back(sb.newest.found_index);
      end else if (r < 48) begin
        send_request(tsp_pkg::FN_CLAIM, 16'($urandom), 4'($urandom), 16'($urandom),
                     pick_now());
        if (sb.newest.hit) begin
          held_q.push_back(sb.newest.found_index);
          load_slot = sb.newest.found_index;
        end
      end else if (r < 68) begin
        if (held_q.size() > 0) begin
          pos = $urandom_range(0, held_q.size() - 1);
          s   = 4'(held_q[pos]);
          held_q.delete(pos);
        end else begin
          s = 4'($urandom);
        end
        send_request(tsp_pkg::FN_RELEASE, 16'($urandom), s, 16'($urandom), $urandom);
      end else if (r < 80) begin
        send_request(tsp_pkg::FN_LOAD, pick_tag(), 4'($urandom), pick_ctx(), pick_now());
      end else if (r < 88) begin
        send_request(tsp_pkg::FN_FLUSH, 16'($urandom), 4'($urandom), 16'($urandom),
                     $urandom);
      end else if (r < 94) begin
        send_request(3'($urandom), 16'($urandom), 4'($urandom), 16'($urandom), $urandom);
      end else begin
        send_request(tsp_pkg::FN_RELEASE, pick_tag(), 4'($urandom), pick_ctx(),
                     pick_now());
      end
    end
  endtask

  // Response side: random stalls, check each accepted transaction
  initial begin
    int               stall;
    tsp_pkg::result_t got;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = snk_steady ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      got.hit             = rsp_ch.hit;
      got.found_index     = rsp_ch.found_index;
      got.clone_count     = rsp_ch.clone_count;
      got.evicted         = rsp_ch.evicted;
      got.evicted_context = rsp_ch.evicted_context;
      sb.check_outcome(got);
    end
  end

  // Main sequence
  initial begin
    logic [4:0] scan_plan[8];
    int         plan_len[8];
    sb                = new();
    src_steady        = 1'b0;
    snk_steady        = 1'b0;
    clock_now         = 32'd1000;
    load_slot         = -1;
    scan_plan         = '{5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd9, 5'd2, 5'd16};
    plan_len          = '{300, 250, 150, 250, 40, 250, 200, 240};
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= tsp_pkg::FN_FIND;
    req_ch.tag        <= '0;
    req_ch.slot_index <= '0;
    req_ch.context_id <= '0;
    req_ch.now        <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, tag keep on load, clones, flush of a live slot
    send_request(tsp_pkg::FN_FIND, 16'h0000, 4'd0, 16'h0000, 32'd0);
    send_request(tsp_pkg::FN_FLUSH, 16'h0000, 4'd3, 16'h0000, 32'd0);
    send_request(tsp_pkg::FN_CLAIM, 16'h0000, 4'd0, 16'h0000, 32'd1);
    send_request(tsp_pkg::FN_LOAD, 16'hFFFF, 4'd0, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(tsp_pkg::FN_LOAD, 16'h0000, 4'd1, 16'h0001, 32'd0);
    send_request(tsp_pkg::FN_LOAD, 16'hFFFF, 4'd15, 16'h8000, 32'd5);
    send_request(tsp_pkg::FN_FIND, 16'hFFFF, 4'd0, 16'h0000, 32'd7);
    send_request(tsp_pkg::FN_FIND, 16'hFFFF, 4'd0, 16'h0000, 32'd8);
    send_request(tsp_pkg::FN_FIND, 16'h0000, 4'd0, 16'h0000, 32'd9);
    send_request(tsp_pkg::FN_LOAD, 16'h0000, 4'd1, 16'h00AA, 32'd0);
    send_request(tsp_pkg::FN_RELEASE, 16'h0000, 4'd0, 16'h0000, 32'd0);
    send_request(tsp_pkg::FN_RELEASE, 16'h0000, 4'd15, 16'h0000, 32'd0);
    send_request(tsp_pkg::FN_RELEASE, 16'h0000, 4'd1, 16'h0000, 32'd0);
    send_request(tsp_pkg::FN_FLUSH, 16'h0000, 4'd15, 16'h0000, 32'd0);
    send_request(3'(tsp_pkg::FN_RELEASE + 3'd3), 16'hFFFF, 4'd15, 16'hFFFF,
                 32'hFFFF_FFFF);

    // Directed: eviction order by age, zero stamp not special, all busy
    drain_pool();
    write_scan_limit(5'd3);
    send_request(tsp_pkg::FN_LOAD, 16'h1234, 4'd2, 16'h0009, 32'd100);
    repeat (4) send_request(tsp_pkg::FN_CLAIM, 16'h0000, 4'd0, 16'h0000, 32'd200);
    send_request(tsp_pkg::FN_RELEASE, 16'h0000, 4'd0, 16'h0000, 32'd0);
    send_request(tsp_pkg::FN_RELEASE, 16'h0000, 4'd1, 16'h0000, 32'd0);
    send_request(tsp_pkg::FN_RELEASE, 16'h0000, 4'd2, 16'h0000, 32'd0);
    send_request(tsp_pkg::FN_LOAD, 16'h0005, 4'd0, 16'h0005, 32'd50);
    send_request(tsp_pkg::FN_LOAD, 16'h0006, 4'd1, 16'h0006, 32'd50);

    // Directed: tie goes to the lowest index
    drain_pool();
    write_scan_limit(5'd2);
    send_request(tsp_pkg::FN_CLAIM, 16'h0000, 4'd0, 16'h0000, 32'd60);
    send_request(tsp_pkg::FN_RELEASE, 16'h0000, 4'd0, 16'h0000, 32'd0);

    // Directed: zero scan length finds nothing
    drain_pool();
    write_scan_limit(5'd0);
    send_request(tsp_pkg::FN_FIND, 16'h0006, 4'd0, 16'h0000, 32'd70);
    send_request(tsp_pkg::FN_CLAIM, 16'h0000, 4'd0, 16'h0000, 32'd71);

    // Random phases over several scan lengths
    for (int p = 0; p < 8; p++) begin
      drain_pool();
      write_scan_limit(scan_plan[p]);
      src_steady = ($urandom_range(0, 3) == 0);
      snk_steady = ($urandom_range(0, 3) == 0);
      held_q.delete();
      load_slot = -1;
      run_traffic(plan_len[p]);
    end

    drain_pool();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/tsp_pkg.sv
design/tsp_if.sv
design/tsp_slot_mem.sv
design/tsp_seq.sv
design/tagged_slot_pool_lru.sv
test/tagged_slot_pool_lru_tb.sv
